### sv/tlsrr_pkg.sv
// ----------------------------------------------------------------------------
// tlsrr_pkg
// Types and constants for the reply record reader: record header layout, beat
// payloads, status and error codes, actions, register indexes and register reset values.
// ----------------------------------------------------------------------------
package tlsrr_pkg;

	// record header layout
	localparam logic [2:0] HEADER_BYTES      = 3'd5;
	localparam logic [2:0] HDR_TYPE_POS      = 3'd0;
	localparam logic [2:0] HDR_LEN_HI_POS    = 3'd3;
	localparam logic [7:0] FIRST_RECORD_TYPE = 8'h16;

	// actions
	localparam logic [1:0] ACT_DATA     = 2'd0;
	localparam logic [1:0] ACT_CLOSED   = 2'd1;
	localparam logic [1:0] ACT_DEADLINE = 2'd2;

	// status
	localparam logic [1:0] STATUS_PENDING = 2'd0;
	localparam logic [1:0] STATUS_DONE    = 2'd1;
	localparam logic [1:0] STATUS_FAILED  = 2'd2;

	// errors
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_PROTOCOL = 2'd1;
	localparam logic [1:0] ERR_EOF      = 2'd2;
	localparam logic [1:0] ERR_TIMEOUT  = 2'd3;

	// register indexes
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_COUNT = 2'd2;

	// register reset values
	localparam logic [15:0] MAX_BODY_LEN_RST = 16'd16384;
	localparam logic [7:0]  PREFIX_LEN_RST   = 8'd112;
	localparam logic [2:0]  RECORD_COUNT_RST = 3'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  error_code;
		logic        prefix_valid;
		logic [7:0]  prefix_index;
		logic [7:0]  prefix_byte;
		logic [2:0]  record_number;
		logic [15:0] bytes_left;
	} rsp_t;

endpackage

### sv/tls_reply_record_reader.sv
// ----------------------------------------------------------------------------
// tls_reply_record_reader
// Deframes a server reply byte by byte: 5-byte record headers, body length
// checks, first-record prefix capture, and done / failed reporting.
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns exactly one result beat per request,
// registered and valid in the cycle after acceptance. All parsing for a byte
// is combinational between the parser state registers and the result
// register; req_ready is high whenever the result register is empty or is
// being taken in the same cycle, so a sustained rate of one byte per clock
// holds as long as the consumer keeps rsp_ready high. Register writes are to
// be made only while no beat is in flight.
module tls_reply_record_reader (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  tlsrr_pkg::req_t                       req,
	output logic                                  rsp_valid,
	input  logic                                  rsp_ready,
	output tlsrr_pkg::rsp_t                       rsp,
	input  logic                                  cfg_wr_en,
	input  logic [tlsrr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tlsrr_pkg::CFG_DATA_W-1:0]      cfg_data
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_BODY,
		PH_DONE,
		PH_FAILED
	} phase_t;

	// configuration
	logic [15:0] max_body_len_q;
	logic [7:0]  prefix_len_q;
	logic [2:0]  record_count_q;

	// parser state
	phase_t      phase_q, phase_n;
	logic [2:0]  hdr_cnt_q, hdr_cnt_n;
	logic [7:0]  rec_type_q, rec_type_n;
	logic [7:0]  len_hi_q, len_hi_n;
	logic [15:0] body_total_q, body_total_n;
	logic [15:0] body_done_q, body_done_n;
	logic [2:0]  rec_done_q, rec_done_n;
	logic [7:0]  cap_cnt_q, cap_cnt_n;
	logic [1:0]  err_q, err_n;

	logic            rsp_valid_q;
	tlsrr_pkg::rsp_t rsp_q;
	tlsrr_pkg::rsp_t rsp_n;

	logic        accept;
	logic        finish;
	logic [2:0]  rec_inc;
	logic [15:0] hdr_len;
	logic [15:0] done_inc;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign rec_inc  = rec_done_q + 3'd1;
	assign hdr_len  = {len_hi_q, req.data_byte};
	assign done_inc = body_done_q + 16'd1;

	always_comb begin
		phase_n      = phase_q;
		hdr_cnt_n    = hdr_cnt_q;
		rec_type_n   = rec_type_q;
		len_hi_n     = len_hi_q;
		body_total_n = body_total_q;
		body_done_n  = body_done_q;
		rec_done_n   = rec_done_q;
		cap_cnt_n    = cap_cnt_q;
		err_n        = err_q;
		finish       = 1'b0;
		rsp_n        = '0;

		if (phase_q == PH_HEADER || phase_q == PH_BODY) begin
			case (req.action)
				tlsrr_pkg::ACT_DATA: begin
					if (phase_q == PH_HEADER) begin
						if (hdr_cnt_q == tlsrr_pkg::HDR_TYPE_POS)
							rec_type_n = req.data_byte;
						if (hdr_cnt_q == tlsrr_pkg::HDR_LEN_HI_POS)
							len_hi_n = req.data_byte;
						if (hdr_cnt_q == tlsrr_pkg::HEADER_BYTES - 3'd1) begin
							hdr_cnt_n    = '0;
							body_total_n = hdr_len;
							if (hdr_len > max_body_len_q) begin
								phase_n = PH_FAILED;
								err_n   = tlsrr_pkg::ERR_PROTOCOL;
							end else if (rec_done_q == 3'd0 &&
								(rec_type_q != tlsrr_pkg::FIRST_RECORD_TYPE ||
								 hdr_len < {8'd0, prefix_len_q})) begin
								phase_n = PH_FAILED;
								err_n   = tlsrr_pkg::ERR_PROTOCOL;
							end else begin
								body_done_n = '0;
								phase_n     = PH_BODY;
								finish      = (hdr_len == 16'd0);
							end
						end else begin
							hdr_cnt_n = hdr_cnt_q + 3'd1;
						end
					end else begin
						if (rec_done_q == 3'd0 && cap_cnt_q < prefix_len_q) begin
							rsp_n.prefix_valid = 1'b1;
							rsp_n.prefix_index = cap_cnt_q;
							rsp_n.prefix_byte  = req.data_byte;
							cap_cnt_n          = cap_cnt_q + 8'd1;
						end
						body_done_n = done_inc;
						finish      = (done_inc >= body_total_q);
					end
				end
				tlsrr_pkg::ACT_CLOSED: begin
					phase_n = PH_FAILED;
					err_n   = tlsrr_pkg::ERR_EOF;
				end
				tlsrr_pkg::ACT_DEADLINE: begin
					phase_n = PH_FAILED;
					err_n   = tlsrr_pkg::ERR_TIMEOUT;
				end
				default: ;
			endcase
		end

		// record complete: count it, then either done or back to headers
		if (finish) begin
			rec_done_n = rec_inc;
			if (rec_inc >= record_count_q) begin
				phase_n = PH_DONE;
				err_n   = tlsrr_pkg::ERR_NONE;
			end else begin
				hdr_cnt_n    = '0;
				body_done_n  = '0;
				body_total_n = '0;
				phase_n      = PH_HEADER;
			end
		end

		case (phase_n)
			PH_HEADER: begin
				rsp_n.status     = tlsrr_pkg::STATUS_PENDING;
				rsp_n.bytes_left = {13'd0, tlsrr_pkg::HEADER_BYTES - hdr_cnt_n};
			end
			PH_BODY: begin
				rsp_n.status     = tlsrr_pkg::STATUS_PENDING;
				rsp_n.bytes_left = body_total_n - body_done_n;
			end
			PH_DONE:   rsp_n.status = tlsrr_pkg::STATUS_DONE;
			default:   rsp_n.status = tlsrr_pkg::STATUS_FAILED;
		endcase
		rsp_n.error_code    = err_n;
		rsp_n.record_number = rec_done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_len_q <= tlsrr_pkg::MAX_BODY_LEN_RST;
			prefix_len_q   <= tlsrr_pkg::PREFIX_LEN_RST;
			record_count_q <= tlsrr_pkg::RECORD_COUNT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tlsrr_pkg::CFG_MAX_BODY_LEN: max_body_len_q <= cfg_data;
				tlsrr_pkg::CFG_PREFIX_LEN:   prefix_len_q   <= cfg_data[7:0];
				tlsrr_pkg::CFG_RECORD_COUNT: record_count_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hdr_cnt_q    <= '0;
			rec_type_q   <= '0;
			len_hi_q     <= '0;
			body_total_q <= '0;
			body_done_q  <= '0;
			rec_done_q   <= '0;
			cap_cnt_q    <= '0;
			err_q        <= tlsrr_pkg::ERR_NONE;
		end else if (accept) begin
			phase_q      <= phase_n;
			hdr_cnt_q    <= hdr_cnt_n;
			rec_type_q   <= rec_type_n;
			len_hi_q     <= len_hi_n;
			body_total_q <= body_total_n;
			body_done_q  <= body_done_n;
			rec_done_q   <= rec_done_n;
			cap_cnt_q    <= cap_cnt_n;
			err_q        <= err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			rsp_q <= rsp_n;
	end

`ifndef NO_ASSERTIONS
	// a new beat never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && rsp_valid_q && !rsp_ready))
		else $error("result register overwritten");

	// header byte counter never reaches the header length
	a_hdr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> hdr_cnt_q < tlsrr_pkg::HEADER_BYTES)
		else $error("header counter out of range");

	// terminal results want no more bytes
	a_final_wanted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != tlsrr_pkg::STATUS_PENDING
		|-> rsp_q.bytes_left == 16'd0)
		else $error("terminal result still wants bytes");

	// done carries no error; failed always carries one
	a_done_err: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE |-> err_q == tlsrr_pkg::ERR_NONE) and
		(phase_q == PH_FAILED |-> err_q != tlsrr_pkg::ERR_NONE))
		else $error("error code inconsistent with phase");
`endif

endmodule
